@@ hdl/cdq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    // store depth, power of two (pointers wrap by natural overflow)
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 8;
    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int LEN_W  = 7;

    localparam logic [DATA_W-1:0] EMPTY_MARK = 8'h23;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_DELETE,
        OP_SEARCH,
        OP_REPLACE,
        OP_REVERSE
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_NOKEY
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] value_out;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  length;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/cdq_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cdq_req_if;
    logic                            valid;
    logic                            ready;
    logic [cdq_pkg::OP_W-1:0]        req_type;
    logic [cdq_pkg::DATA_W-1:0]      value_in;
    logic [cdq_pkg::DATA_W-1:0]      new_value;

    modport source (output valid, req_type, value_in, new_value, input ready);
    modport sink   (input valid, req_type, value_in, new_value, output ready);
endinterface

interface cdq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [cdq_pkg::DATA_W-1:0]      value_out;
    logic                            found;
    logic [cdq_pkg::POS_W-1:0]       position;
    logic [cdq_pkg::LEN_W-1:0]       length;
    cdq_pkg::status_t                status;

    modport source (output valid, value_out, found, position, length, status, input ready);
    modport sink   (input valid, value_out, found, position, length, status, output ready);
endinterface

`default_nettype wire

@@ hdl/cdq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/cdq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cdq_req_if.sink            req,
    output logic               res_valid,
    output cdq_pkg::result_t   res,
    input  wire logic          res_ready
);

    localparam int AW = cdq_pkg::ADDR_W;
    localparam int CW = cdq_pkg::CNT_W;
    localparam int DW = cdq_pkg::DATA_W;

    cdq_pkg::state_t  state_reg, state_next;
    cdq_pkg::op_t     op_reg, op_next;
    logic [DW-1:0]    key_reg, key_next;
    logic [DW-1:0]    nval_reg, nval_next;
    logic [AW-1:0]    head_reg, head_next;
    logic             dir_reg, dir_next;
    logic [CW-1:0]    len_reg, len_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic             found_reg, found_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [DW-1:0]    vout_reg, vout_next;
    cdq_pkg::status_t status_reg, status_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    logic accept, full, empty, rd_hit, cmp_last, rd_more;

    // logical position -> memory address; dir set means the order runs downward
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic dir,
                                           input logic [CW-1:0] p);
        logic [AW-1:0] off;
        off = p[AW-1:0];
        return dir ? (head - off) : (head + off);
    endfunction

    cdq_ram #(
        .WIDTH (DW),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == cdq_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;
    assign full      = (len_reg == CW'(cdq_pkg::DEPTH));
    assign empty     = (len_reg == '0);
    assign rd_hit    = cmp_vld_reg && (ram_rdata == key_reg);
    assign cmp_last  = cmp_vld_reg && (cmp_idx_reg == len_reg - CW'(1));
    assign rd_more   = (rd_idx_reg < len_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = cdq_pkg::S_EXEC;
                end
            end
            cdq_pkg::S_EXEC:
            begin
                unique case (op_reg) inside
                    cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK:
                        state_next = empty ? cdq_pkg::S_FINISH : cdq_pkg::S_POP_WAIT;
                    cdq_pkg::OP_DELETE, cdq_pkg::OP_SEARCH, cdq_pkg::OP_REPLACE:
                        state_next = empty ? cdq_pkg::S_FINISH : cdq_pkg::S_SCAN;
                    default:
                        state_next = cdq_pkg::S_FINISH;
                endcase
            end
            cdq_pkg::S_POP_WAIT:
            begin
                state_next = cdq_pkg::S_FINISH;
            end
            cdq_pkg::S_SCAN:
            begin
                if (rd_hit && (op_reg == cdq_pkg::OP_SEARCH))
                begin
                    state_next = cdq_pkg::S_FINISH;
                end
                else if (rd_hit && (op_reg == cdq_pkg::OP_DELETE))
                begin
                    state_next = cmp_last ? cdq_pkg::S_FINISH : cdq_pkg::S_SHIFT;
                end
                else if (cmp_last)
                begin
                    state_next = cdq_pkg::S_FINISH;
                end
            end
            cdq_pkg::S_SHIFT:
            begin
                if (cmp_last)
                begin
                    state_next = cdq_pkg::S_FINISH;
                end
            end
            cdq_pkg::S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = cdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next      = op_reg;
        key_next     = key_reg;
        nval_next    = nval_reg;
        head_next    = head_reg;
        dir_next     = dir_reg;
        len_next     = len_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        vout_next    = vout_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = head_reg;
        ram_wdata    = key_reg;
        ram_re       = 1'b0;
        ram_raddr    = head_reg;

        unique case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = cdq_pkg::op_t'(req.req_type);
                    key_next     = req.value_in;
                    nval_next    = req.new_value;
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    found_next   = 1'b0;
                    pos_next     = '0;
                    vout_next    = '0;
                    status_next  = cdq_pkg::ST_OK;
                end
            end
            cdq_pkg::S_EXEC:
            begin
                unique case (op_reg) inside
                    cdq_pkg::OP_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = cdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            head_next = dir_reg ? (head_reg + AW'(1)) : (head_reg - AW'(1));
                            ram_we    = 1'b1;
                            ram_waddr = head_next;
                            len_next  = len_reg + CW'(1);
                        end
                    end
                    cdq_pkg::OP_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status_next = cdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = phys(head_reg, dir_reg, len_reg);
                            len_next  = len_reg + CW'(1);
                        end
                    end
                    cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK:
                    begin
                        if (empty)
                        begin
                            vout_next   = cdq_pkg::EMPTY_MARK;
                            status_next = cdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_re   = 1'b1;
                            len_next = len_reg - CW'(1);
                            if (op_reg == cdq_pkg::OP_POP_FRONT)
                            begin
                                ram_raddr = head_reg;
                                head_next = phys(head_reg, dir_reg, CW'(1));
                            end
                            else
                            begin
                                ram_raddr = phys(head_reg, dir_reg, len_reg - CW'(1));
                            end
                        end
                    end
                    cdq_pkg::OP_REVERSE:
                    begin
                        // last entry becomes the head, walk direction flips
                        head_next = phys(head_reg, dir_reg, len_reg - CW'(1));
                        dir_next  = ~dir_reg;
                    end
                    default:
                    begin
                        if (empty)
                        begin
                            status_next = cdq_pkg::ST_NOKEY;
                        end
                    end
                endcase
            end
            cdq_pkg::S_POP_WAIT:
            begin
                vout_next = ram_rdata;
            end
            cdq_pkg::S_SCAN:
            begin
                // read one entry ahead of the compare
                ram_re       = rd_more;
                ram_raddr    = phys(head_reg, dir_reg, rd_idx_reg);
                rd_idx_next  = rd_more ? (rd_idx_reg + CW'(1)) : rd_idx_reg;
                cmp_vld_next = rd_more;
                cmp_idx_next = rd_idx_reg;
                if (rd_hit)
                begin
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        pos_next   = cmp_idx_reg + CW'(1);
                    end
                    if (op_reg == cdq_pkg::OP_REPLACE)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = phys(head_reg, dir_reg, cmp_idx_reg);
                        ram_wdata = nval_reg;
                    end
                    if (op_reg == cdq_pkg::OP_DELETE)
                    begin
                        rd_idx_next  = cmp_idx_reg + CW'(1);
                        cmp_vld_next = 1'b0;
                        if (cmp_last)
                        begin
                            len_next = len_reg - CW'(1);
                        end
                    end
                end
                else if (cmp_last && !found_reg)
                begin
                    status_next = cdq_pkg::ST_NOKEY;
                end
            end
            cdq_pkg::S_SHIFT:
            begin
                // close the gap: entry i+1 moves to i
                ram_re       = rd_more;
                ram_raddr    = phys(head_reg, dir_reg, rd_idx_reg);
                rd_idx_next  = rd_more ? (rd_idx_reg + CW'(1)) : rd_idx_reg;
                cmp_vld_next = rd_more;
                cmp_idx_next = rd_idx_reg;
                if (cmp_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(head_reg, dir_reg, cmp_idx_reg - CW'(1));
                    ram_wdata = ram_rdata;
                end
                if (cmp_last)
                begin
                    len_next = len_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cdq_pkg::S_IDLE;
            head_reg    <= '0;
            dir_reg     <= 1'b0;
            len_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            dir_reg     <= dir_next;
            len_reg     <= len_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        nval_reg    <= nval_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        vout_reg    <= vout_next;
        status_reg  <= status_next;
    end

    assign res_valid     = (state_reg == cdq_pkg::S_FINISH);
    assign res.value_out = vout_reg;
    assign res.found     = found_reg;
    assign res.position  = cdq_pkg::POS_W'(pos_reg);
    assign res.length    = cdq_pkg::LEN_W'(len_reg);
    assign res.status    = status_reg;

endmodule

`default_nettype wire

@@ hdl/cdq_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cdq_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_valid,
    input  wire cdq_pkg::result_t res,
    output logic                  res_ready,
    cdq_rsp_if.source             rsp
);

    logic             vld_reg, vld_next;
    cdq_pkg::result_t data_reg;
    logic             load;

    assign res_ready = !vld_reg || rsp.ready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign rsp.valid     = vld_reg;
    assign rsp.value_out = data_reg.value_out;
    assign rsp.found     = data_reg.found;
    assign rsp.position  = data_reg.position;
    assign rsp.length    = data_reg.length;
    assign rsp.status    = data_reg.status;

endmodule

`default_nettype wire

@@ hdl/char_sequence_deque_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Search/delete/replace walk the entries through the single RAM read port,
// one entry a cycle. One item at a time: the next beat is taken in the cycle
// after the result moves into the output register. Reset clears length and
// pointers; no memory clear pass.
module char_sequence_deque_store (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cdq_req_if.sink    req,
    cdq_rsp_if.source  rsp
);

    logic             res_valid;
    logic             res_ready;
    cdq_pkg::result_t res;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    cdq_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ hdl/cdq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cdq_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [cdq_pkg::DATA_W-1:0]  rsp_value_out,
    input wire logic                        rsp_found,
    input wire logic [cdq_pkg::POS_W-1:0]   rsp_position,
    input wire logic [cdq_pkg::LEN_W-1:0]   rsp_length,
    input wire logic [1:0]                  rsp_status
);

    // beats accepted but not yet answered
    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if ((req_valid && req_ready) && !(rsp_valid && rsp_ready))
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready))
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_length))
        else $error("result beat dropped or changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result beat without an accepted request");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == cdq_pkg::ST_FULL |->
            rsp_length == cdq_pkg::LEN_W'(cdq_pkg::DEPTH) && !rsp_found && rsp_position == '0)
        else $error("full status with length below capacity");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == cdq_pkg::ST_EMPTY |->
            rsp_length == '0 && rsp_value_out == cdq_pkg::EMPTY_MARK)
        else $error("empty status with entries held or wrong marker");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |->
            rsp_status == cdq_pkg::ST_OK && rsp_position != '0 &&
            ({1'b0, rsp_position} <= {1'b0, rsp_length} + 8'd1))
        else $error("match reported with bad position or status");

endmodule

bind char_sequence_deque_store cdq_checker u_cdq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value_out (rsp.value_out),
    .rsp_found     (rsp.found),
    .rsp_position  (rsp.position),
    .rsp_length    (rsp.length),
    .rsp_status    (rsp.status)
);

`default_nettype wire
